/* rtl/mcwm_pkg.sv */
`default_nettype none
package mcwm_pkg;

	localparam int CHANNELS_DEF = 24;
	localparam int WINDOW_DEF   = 5;
	localparam int CHAN_W       = 5;
	localparam int SAMPLE_W     = 16;
	// Fields in tdata plus zero fill up to whole bytes.
	localparam int TDATA_W      = ((CHAN_W + SAMPLE_W + 7) / 8) * 8;

	// Verdict of the rank unit on one candidate element of a window.
	typedef struct packed {
		logic                       hit;
		logic signed [SAMPLE_W-1:0] value;
	} rank_res_t;

endpackage
`default_nettype wire

/* rtl/multichannel_window_median.sv */
`default_nettype none
// An accepted input beat passes through a row read with write-back, one rank-unit pass per
// candidate up to the median, and an output step that waits in ST_DONE until m_tdata is free.
// s_tready is high only while the sequencer is idle, so a new beat is taken only after the
// last result is registered; a channel past the store skips the rank-unit passes.
// Reset: arst_n clears the sequencer, the output valid and the per-channel row valid bits,
// so every window reads as all zero after reset. No clearing pass is needed.
module multichannel_window_median #(
	parameter int CHANNELS = mcwm_pkg::CHANNELS_DEF,
	parameter int WINDOW   = mcwm_pkg::WINDOW_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         s_tvalid,
	output logic                              s_tready,
	// s_tdata: channel [4:0], sample [20:5], zero fill above.
	input  wire logic [mcwm_pkg::TDATA_W-1:0] s_tdata,
	output logic                              m_tvalid,
	input  wire logic                         m_tready,
	// m_tdata: channel_out [4:0], median [20:5], zero fill above.
	output logic [mcwm_pkg::TDATA_W-1:0]      m_tdata
);
	import mcwm_pkg::*;

	localparam int ROW_W = WINDOW * SAMPLE_W;
	// Row address width, kept at least one bit for a single channel.
	localparam int AW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	// Candidate index width, kept at least one bit for a window of one.
	localparam int IW    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int FILL  = TDATA_W - CHAN_W - SAMPLE_W;

	// The sequencer reads the channel's row, shifts in the new sample and
	// writes it back, then walks the candidates through the rank unit.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_RANK,
		ST_DONE
	} state_t;

	state_t                     state_q;
	logic [CHAN_W-1:0]          ch_q;
	logic signed [SAMPLE_W-1:0] samp_q;
	logic                       in_range_q;
	logic [ROW_W-1:0]           win_q;
	logic [IW-1:0]              cand_q;
	logic signed [SAMPLE_W-1:0] med_q;
	logic                       m_tvalid_q;
	logic [TDATA_W-1:0]         m_tdata_q;

	logic                       in_beat;
	logic [CHAN_W-1:0]          in_ch;
	logic [AW+CHAN_W-1:0]       in_ch_ext;
	logic [AW+CHAN_W-1:0]       ch_q_ext;
	logic [AW-1:0]              rd_addr;
	logic [AW-1:0]              wr_addr;
	logic [ROW_W-1:0]           rd_data;
	logic [ROW_W+SAMPLE_W-1:0]  shifted;
	logic [ROW_W-1:0]           new_row;
	logic                       wr_en;
	logic                       out_free;
	rank_res_t                  rank_res;

	assign in_beat   = s_tvalid && s_tready;
	assign in_ch     = s_tdata[CHAN_W-1:0];
	assign in_ch_ext = {{AW{1'b0}}, in_ch};
	assign ch_q_ext  = {{AW{1'b0}}, ch_q};
	assign rd_addr   = in_ch_ext[AW-1:0];
	assign wr_addr   = ch_q_ext[AW-1:0];

	// The oldest sample falls off the top; the new one enters slot 0.
	assign shifted = {rd_data, samp_q};
	assign new_row = shifted[ROW_W-1:0];
	assign wr_en   = (state_q == ST_READ) && in_range_q;

	assign out_free = !m_tvalid_q || m_tready;

	mcwm_store #(
		.CHANNELS (CHANNELS),
		.WINDOW   (WINDOW),
		.AW       (AW)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (in_beat),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (new_row)
	);

	mcwm_rank #(
		.WINDOW (WINDOW),
		.IW     (IW)
	) u_rank (
		.win  (win_q),
		.cand (cand_q),
		.res  (rank_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			// In ST_DONE a taken result beat is replaced by the next one below.
			if (m_tvalid_q && m_tready && (state_q != ST_DONE)) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_beat) begin
						ch_q       <= in_ch;
						samp_q     <= s_tdata[CHAN_W +: SAMPLE_W];
						in_range_q <= (7'(in_ch) < 7'(CHANNELS));
						state_q    <= ST_READ;
					end
				end
				ST_READ: begin
					// An out-of-range channel leaves the history alone and yields zero.
					win_q  <= new_row;
					cand_q <= '0;
					med_q  <= '0;
					state_q <= in_range_q ? ST_RANK : ST_DONE;
				end
				ST_RANK: begin
					if (rank_res.hit) begin
						med_q   <= rank_res.value;
						state_q <= ST_DONE;
					end else begin
						cand_q <= cand_q + IW'(1);
					end
				end
				ST_DONE: begin
					if (out_free) begin
						m_tdata_q  <= {{FILL{1'b0}}, med_q, ch_q};
						m_tvalid_q <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule
`default_nettype wire

/* rtl/mcwm_store.sv */
`default_nettype none
module mcwm_store #(
	parameter int CHANNELS = 24,
	parameter int WINDOW   = 5,
	parameter int AW       = 5
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  rd_en,
	input  wire logic [AW-1:0]                         rd_addr,
	output logic [WINDOW*mcwm_pkg::SAMPLE_W-1:0]       rd_data,
	input  wire logic                                  wr_en,
	input  wire logic [AW-1:0]                         wr_addr,
	input  wire logic [WINDOW*mcwm_pkg::SAMPLE_W-1:0]  wr_data
);
	import mcwm_pkg::*;

	localparam int ROW_W = WINDOW * SAMPLE_W;

	// One row per channel holds its whole window, slot 0 in the low bits.
	logic [ROW_W-1:0]    mem [CHANNELS];
	logic [CHANNELS-1:0] row_valid_q;
	logic [ROW_W-1:0]    rd_q;
	logic                rd_valid_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	// A row never written since reset reads as all zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
			rd_valid_q  <= 1'b0;
		end else begin
			if (wr_en) begin
				row_valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_valid_q <= row_valid_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_valid_q ? rd_q : '0;

endmodule
`default_nettype wire

/* rtl/mcwm_rank.sv */
`default_nettype none
module mcwm_rank #(
	parameter int WINDOW = 5,
	parameter int IW     = 3
) (
	input  wire logic [WINDOW*mcwm_pkg::SAMPLE_W-1:0] win,
	input  wire logic [IW-1:0]                        cand,
	output mcwm_pkg::rank_res_t                       res
);
	import mcwm_pkg::*;

	localparam int CW   = $clog2(WINDOW + 1);
	localparam int HALF = WINDOW / 2;

	logic signed [SAMPLE_W-1:0] cand_val;
	logic [WINDOW-1:0]          lt_vec;
	logic [WINDOW-1:0]          eq_vec;
	logic [CW-1:0]              n_lt;
	logic [CW:0]                n_le;

	always_comb begin
		cand_val = '0;
		for (int i = 0; i < WINDOW; i++) begin
			if (cand == IW'(i)) begin
				cand_val = win[i*SAMPLE_W +: SAMPLE_W];
			end
		end
	end

	// Compare the candidate against every slot at once.
	always_comb begin
		for (int j = 0; j < WINDOW; j++) begin
			lt_vec[j] = $signed(win[j*SAMPLE_W +: SAMPLE_W]) < cand_val;
			eq_vec[j] = $signed(win[j*SAMPLE_W +: SAMPLE_W]) == cand_val;
		end
	end

	assign n_lt = CW'($countones(lt_vec));
	assign n_le = (CW+1)'(n_lt) + (CW+1)'($countones(eq_vec));

	// The candidate sits at sorted index HALF when fewer than HALF+1 elements
	// are below it and more than HALF are at or below it.
	assign res.hit   = (n_lt <= CW'(HALF)) && (n_le > (CW+1)'(HALF));
	assign res.value = cand_val;

endmodule
`default_nettype wire
